[hdl/gf2m_pkg.sv]
// Shared types and constants for the GF(2^m) multiply / power / inverse unit.
// No dependencies; imported by every module of the unit.
package gf2m_pkg;

    localparam int CFG_DATA_W = 17;
    localparam int CFG_IDX_W  = 1;
    localparam int DEG_W      = 5;
    localparam int WORD_W     = 16;

    localparam logic [CFG_IDX_W-1:0] REG_DEGREE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_POLY   = 1'b1;

    localparam logic [DEG_W-1:0]      DEGREE_RST = 5'd8;
    localparam logic [CFG_DATA_W-1:0] POLY_RST   = 17'd285;
    localparam logic [DEG_W-1:0]      DEGREE_MIN = 5'd2;

    typedef enum logic [1:0] {
        OP_MUL = 2'd0,
        OP_POW = 2'd1,
        OP_INV = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_ACC,
        S_SQR,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_MUL,
        CMD_ACC,
        CMD_SQR
    } t_dp_cmd;

    typedef struct packed {
        logic exp_zero;
        logic exp_lsb;
    } t_dp_status;

endpackage

[hdl/gf2m_ctrl.sv]
// Sequencer for the GF(2^m) unit: square-and-multiply stepping and result strobe.
// Depends on gf2m_pkg; drives the datapath through t_dp_cmd, reads t_dp_status.
module gf2m_ctrl
    import gf2m_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    input  logic [1:0] i_operation,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd,
    output logic       busy,
    output logic       o_done
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = CMD_NONE;
        busy    = 1'b1;
        o_done  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    o_cmd = CMD_LOAD;
                    case (i_operation)
                        OP_MUL:  n_state = S_MUL;
                        OP_POW:  n_state = S_ACC;
                        OP_INV:  n_state = S_ACC;
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_MUL: begin
                o_cmd   = CMD_MUL;
                n_state = S_DONE;
            end
            S_ACC: begin
                if (i_status.exp_zero) begin
                    n_state = S_DONE;
                end else begin
                    if (i_status.exp_lsb) begin
                        o_cmd = CMD_ACC;
                    end
                    n_state = S_SQR;
                end
            end
            S_SQR: begin
                o_cmd   = CMD_SQR;
                n_state = S_ACC;
            end
            S_DONE: begin
                o_done  = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    a_done_then_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !busy)
        else $error("strobe not followed by idle");

    a_start_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not raise busy");

    a_sqr_after_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd == CMD_SQR) |-> $past(r_state) == S_ACC)
        else $error("squaring step not preceded by accumulate step");

endmodule

[hdl/gf2m_dpath.sv]
// Datapath for the GF(2^m) unit: config registers, operand registers, shared field multiplier.
// Depends on gf2m_pkg; commanded by gf2m_ctrl.
module gf2m_dpath
    import gf2m_pkg::*;
#(
    parameter int MAX_DEGREE = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_dp_cmd               i_cmd,
    input  logic [1:0]            i_operation,
    input  logic [WORD_W-1:0]     i_operand_a,
    input  logic [WORD_W-1:0]     i_operand_b,
    output t_dp_status            o_status,
    output logic [WORD_W-1:0]     o_field_result
);

    localparam int W  = MAX_DEGREE;
    localparam int EW = (MAX_DEGREE > WORD_W) ? MAX_DEGREE : WORD_W;

    logic [DEG_W-1:0]      r_degree;
    logic [CFG_DATA_W-1:0] r_poly;
    logic [W-1:0]          r_acc;
    logic [W-1:0]          r_base;
    logic [EW-1:0]         r_exp;

    logic [DEG_W-1:0] m_eff;
    logic [W-1:0]     mask;
    logic [W-1:0]     top;
    logic [W-1:0]     poly_lo;
    logic [W-1:0]     a_m;
    logic [W-1:0]     b_m;
    logic [W-1:0]     mul_x;
    logic [W-1:0]     mul_y;
    logic [W-1:0]     mul_p;
    logic [W-1:0]     sh;
    logic [31:0]      acc_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_degree <= DEGREE_RST;
            r_poly   <= POLY_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_DEGREE: r_degree <= i_cfg_data[DEG_W-1:0];
                REG_POLY:   r_poly   <= i_cfg_data;
                default:    r_poly   <= r_poly;
            endcase
        end
    end

    always_comb begin
        if (r_degree < DEGREE_MIN) begin
            m_eff = DEGREE_MIN;
        end else if (r_degree > DEG_W'(MAX_DEGREE)) begin
            m_eff = DEG_W'(MAX_DEGREE);
        end else begin
            m_eff = r_degree;
        end
        for (int i = 0; i < W; i++) begin
            mask[i] = (DEG_W'(i) < m_eff);
        end
    end

    assign top     = mask ^ (mask >> 1);
    assign poly_lo = W'(r_poly) & mask;
    assign a_m     = W'(i_operand_a) & mask;
    assign b_m     = W'(i_operand_b) & mask;

    always_comb begin
        unique case (i_cmd)
            CMD_MUL: begin
                mul_x = r_base;
                mul_y = r_exp[W-1:0];
            end
            CMD_SQR: begin
                mul_x = r_base;
                mul_y = r_base;
            end
            default: begin
                mul_x = r_acc;
                mul_y = r_base;
            end
        endcase
    end

    // shift-and-add with reduction
    always_comb begin
        sh    = mul_x & mask;
        mul_p = '0;
        for (int i = 0; i < W; i++) begin
            if (mul_y[i]) begin
                mul_p = mul_p ^ sh;
            end
            if ((sh & top) != '0) begin
                sh = ((sh << 1) & mask) ^ poly_lo;
            end else begin
                sh = (sh << 1) & mask;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd)
            CMD_LOAD: begin
                r_base <= a_m;
                case (i_operation)
                    OP_MUL: begin
                        r_acc <= W'(1);
                        r_exp <= EW'(b_m);
                    end
                    OP_POW: begin
                        r_acc <= W'(1);
                        r_exp <= EW'(i_operand_b);
                    end
                    OP_INV: begin
                        r_acc <= W'(1);
                        r_exp <= EW'(mask - W'(1));
                    end
                    default: begin
                        r_acc <= '0;
                        r_exp <= '0;
                    end
                endcase
            end
            CMD_MUL: r_acc <= mul_p;
            CMD_ACC: r_acc <= mul_p;
            CMD_SQR: begin
                r_base <= mul_p;
                r_exp  <= r_exp >> 1;
            end
            default: begin
                r_acc <= r_acc;
            end
        endcase
    end

    assign o_status.exp_zero = (r_exp == '0);
    assign o_status.exp_lsb  = r_exp[0];

    assign acc_ext        = 32'(r_acc);
    assign o_field_result = acc_ext[WORD_W-1:0];

    a_sqr_halves_exp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd == CMD_SQR) |=> r_exp == ($past(r_exp) >> 1))
        else $error("exponent not advanced on squaring");

    a_acc_in_field: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((i_cmd == CMD_ACC) && !i_cfg_we) |=> (r_acc & ~mask) == '0)
        else $error("accumulator left the field");

endmodule

[hdl/gf2m_multiply_power_inverse_unit.sv]
// GF(2^m) multiply / power / inverse unit, one shared combinational field multiplier.
// Multiply: load, one multiply step, strobe. Power and inverse: load, then an accumulate
// and a squaring step for each of the n exponent bits (inverse: n = m), then strobe.
// Next word taken in the cycle after the strobe; no receiver stall.
// Synchronous active-low reset: idle, degree 8, polynomial 0x11D.
// Depends on gf2m_pkg, gf2m_ctrl, gf2m_dpath.
module gf2m_multiply_power_inverse_unit
    import gf2m_pkg::*;
#(
    parameter int MAX_DEGREE = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            i_operation,
    input  logic [WORD_W-1:0]     i_operand_a,
    input  logic [WORD_W-1:0]     i_operand_b,
    output logic                  o_done,
    output logic [WORD_W-1:0]     o_field_result
);

    t_dp_cmd    cmd;
    t_dp_status status;

    gf2m_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_operation (i_operation),
        .i_status    (status),
        .o_cmd       (cmd),
        .busy        (busy),
        .o_done      (o_done)
    );

    gf2m_dpath #(
        .MAX_DEGREE (MAX_DEGREE)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_cmd          (cmd),
        .i_operation    (i_operation),
        .i_operand_a    (i_operand_a),
        .i_operand_b    (i_operand_b),
        .o_status       (status),
        .o_field_result (o_field_result)
    );

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
// Self-checking bench for gf2m_multiply_power_inverse_unit: multiply, power and inverse
// words over many field settings, checked against a bit-level field arithmetic predictor.
// Depends on gf2m_pkg and the unit's RTL.
module testbench;
    import gf2m_pkg::*;

    localparam int FIELD_DEG_MAX = 16;
    localparam logic [1:0] OP_SPARE = 2'd3;
    localparam int N_SETTINGS = 14;
    localparam int WORDS_PER_SETTING = 130;

    class field_result_tracker;
        logic [DEG_W-1:0]      degree_reg;
        logic [CFG_DATA_W-1:0] poly_reg;
        logic [WORD_W-1:0]     pending_results[$];
        int                    errors;
        int                    checked;
        int                    op_seen[4];

        function new();
            degree_reg = DEGREE_RST;
            poly_reg   = POLY_RST;
            errors     = 0;
            checked    = 0;
            foreach (op_seen[i]) op_seen[i] = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_DEGREE) degree_reg = data[DEG_W-1:0];
            else if (idx == REG_POLY) poly_reg = data;
        endfunction

        function int unsigned degree();
            if (degree_reg < DEGREE_MIN) return 32'(DEGREE_MIN);
            if (degree_reg > FIELD_DEG_MAX) return FIELD_DEG_MAX;
            return 32'(degree_reg);
        endfunction

        function logic [WORD_W-1:0] field_mul(logic [WORD_W-1:0] a_in, logic [WORD_W-1:0] b_in);
            int unsigned m, mask, low, top, a, b, acc;
            m    = degree();
            mask = (1 << m) - 1;
            low  = poly_reg & mask;
            top  = 1 << (m - 1);
            a    = a_in & mask;
            b    = b_in & mask;
            acc  = 0;
            for (int i = 0; i < m; i++) begin
                if (b[0]) acc = acc ^ a;
                b = b >> 1;
                if ((a & top) != 0) a = ((a << 1) & mask) ^ low;
                else a = (a << 1) & mask;
            end
            acc = acc & mask;
            return acc[WORD_W-1:0];
        endfunction

        function logic [WORD_W-1:0] field_pow(logic [WORD_W-1:0] base_in, logic [WORD_W-1:0] e_in);
            logic [WORD_W-1:0] acc, base, e;
            int unsigned       mask;
            mask = (1 << degree()) - 1;
            acc  = WORD_W'(1);
            base = base_in & mask[WORD_W-1:0];
            e    = e_in;
            while (e != 0) begin
                if (e[0]) acc = field_mul(acc, base);
                base = field_mul(base, base);
                e    = e >> 1;
            end
            return acc;
        endfunction

        function logic [WORD_W-1:0] predict_word(logic [1:0] op, logic [WORD_W-1:0] a,
                                                 logic [WORD_W-1:0] b);
            int unsigned inv_exp;
            inv_exp = (1 << degree()) - 2;
            case (op)
                OP_MUL:  return field_mul(a, b);
                OP_POW:  return field_pow(a, b);
                OP_INV:  return field_pow(a, inv_exp[WORD_W-1:0]);
                default: return '0;
            endcase
        endfunction

        function void note_word(logic [1:0] op, logic [WORD_W-1:0] a, logic [WORD_W-1:0] b);
            pending_results.push_back(predict_word(op, a, b));
            op_seen[op]++;
        endfunction

        function void check_word(logic [WORD_W-1:0] actual);
            logic [WORD_W-1:0] want;
            if (pending_results.size() == 0) begin
                $error("field_result: expected none, actual %h", actual);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            checked++;
            if (actual !== want) begin
                $error("field_result: expected %h, actual %h", want, actual);
                errors++;
            end
        endfunction

        function int pending();
            return pending_results.size();
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [1:0]            i_operation = OP_MUL;
    logic [WORD_W-1:0]     i_operand_a = '0;
    logic [WORD_W-1:0]     i_operand_b = '0;
    logic                  o_done;
    logic [WORD_W-1:0]     o_field_result;

    field_result_tracker tracker = new();
    int settings_seen = 1;

    gf2m_multiply_power_inverse_unit #(.MAX_DEGREE(FIELD_DEG_MAX)) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .start          (start),
        .busy           (busy),
        .i_operation    (i_operation),
        .i_operand_a    (i_operand_a),
        .i_operand_b    (i_operand_b),
        .o_done         (o_done),
        .o_field_result (o_field_result)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we) tracker.set_register(i_cfg_index, i_cfg_data);
            if (start && !busy) tracker.note_word(i_operation, i_operand_a, i_operand_b);
            if (o_done) tracker.check_word(o_field_result);
        end
    end

    function automatic logic [CFG_DATA_W-1:0] irreducible_poly(int unsigned m);
        case (m)
            2:       return 17'h00007;
            3:       return 17'h0000B;
            4:       return 17'h00013;
            5:       return 17'h00025;
            6:       return 17'h00043;
            7:       return 17'h00083;
            8:       return 17'h0011D;
            9:       return 17'h00211;
            10:      return 17'h00409;
            11:      return 17'h00805;
            12:      return 17'h01053;
            13:      return 17'h0201B;
            14:      return 17'h04443;
            15:      return 17'h08003;
            default: return 17'h1100B;
        endcase
    endfunction

    function automatic logic [WORD_W-1:0] rand_element();
        int unsigned width;
        width = $urandom_range(1, WORD_W);
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 16'd1;
            2:       return '1;
            3, 4, 5: return WORD_W'($urandom & ((1 << width) - 1));
            default: return WORD_W'($urandom);
        endcase
    endfunction

    function automatic logic [WORD_W-1:0] rand_exponent();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 16'd1;
            2:       return '1;
            3, 4:    return WORD_W'($urandom_range(2, 15));
            default: return WORD_W'($urandom);
        endcase
    endfunction

    function automatic logic [1:0] rand_op();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r == 0) return OP_SPARE;
        if (r <= 7) return OP_MUL;
        if (r <= 13) return OP_POW;
        return OP_INV;
    endfunction

    task automatic send_word(input logic [1:0] op, input logic [WORD_W-1:0] a,
                             input logic [WORD_W-1:0] b);
        i_operation <= op;
        i_operand_a <= a;
        i_operand_b <= b;
        start       <= 1'b1;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic pause_sender(input bit steady);
        int unsigned n;
        n = 0;
        if (!steady) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: n = 0;
                6, 7, 8:          n = $urandom_range(1, 3);
                default:          n = $urandom_range(4, 40);
            endcase
        end
        if (n != 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        do @(posedge i_clk); while (tracker.pending() != 0 || busy);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin
        int unsigned           deg;
        logic [CFG_DATA_W-1:0] poly;
        logic [CFG_DATA_W-1:0] deg_word;
        logic [1:0]            op;
        bit                    steady;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset field: degree 8, polynomial 0x11D
        send_word(OP_MUL, 16'h0000, 16'h0000);
        send_word(OP_MUL, 16'hFFFF, 16'hFFFF);
        send_word(OP_MUL, 16'h0001, 16'h00A5);
        send_word(OP_MUL, 16'h8000, 16'h0080);
        send_word(OP_MUL, 16'h0080, 16'h0080);
        send_word(OP_POW, 16'h0002, 16'h0000);
        send_word(OP_POW, 16'h0000, 16'h0000);
        send_word(OP_POW, 16'h0000, 16'h0005);
        send_word(OP_POW, 16'h0003, 16'hFFFF);
        send_word(OP_POW, 16'h0053, 16'h8000);
        send_word(OP_POW, 16'hFFFF, 16'h0001);
        send_word(OP_POW, 16'h00FF, 16'h00FE);
        send_word(OP_INV, 16'h0000, 16'h0000);
        send_word(OP_INV, 16'h0001, 16'hFFFF);
        send_word(OP_INV, 16'h0002, 16'h0000);
        send_word(OP_INV, 16'hFFFF, 16'h1234);
        send_word(OP_INV, 16'h00FF, 16'h0000);
        send_word(OP_SPARE, 16'hFFFF, 16'hFFFF);
        send_word(OP_SPARE, 16'h0000, 16'h0000);

        for (int p = 0; p < N_SETTINGS; p++) begin
            drain();
            case (p)
                0: begin deg = 2;  poly = irreducible_poly(2); end
                1: begin deg = 16; poly = irreducible_poly(16); end
                2: begin deg = 0;  poly = CFG_DATA_W'($urandom); end
                3: begin deg = 31; poly = '1; end
                4: begin deg = 1;  poly = '0; end
                5: begin deg = 17; poly = CFG_DATA_W'($urandom); end
                default: begin
                    deg  = $urandom_range(2, 16);
                    poly = ($urandom_range(0, 3) == 0) ? 17'($urandom) : irreducible_poly(deg);
                end
            endcase
            deg_word = CFG_DATA_W'($urandom);
            deg_word[DEG_W-1:0] = deg[DEG_W-1:0];
            if ($urandom_range(0, 1) == 0) deg_word[CFG_DATA_W-1:DEG_W] = '0;
            write_register(REG_DEGREE, deg_word);
            write_register(REG_POLY, poly);
            settings_seen++;
            steady = ($urandom_range(0, 2) == 0);
            for (int i = 0; i < WORDS_PER_SETTING; i++) begin
                pause_sender(steady);
                op = rand_op();
                send_word(op, rand_element(), (op == OP_POW) ? rand_exponent() : rand_element());
            end
        end

        drain();
        repeat (40) @(posedge i_clk);
        $display("tb: %0d words checked over %0d field settings", tracker.checked, settings_seen);
        $display("tb: multiply %0d, power %0d, inverse %0d, spare code %0d",
                 tracker.op_seen[OP_MUL], tracker.op_seen[OP_POW],
                 tracker.op_seen[OP_INV], tracker.op_seen[OP_SPARE]);
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #1_000_000;
        $display("tb: failure");
        $finish;
    end
endmodule

[sim.f]
hdl/gf2m_pkg.sv
hdl/gf2m_ctrl.sv
hdl/gf2m_dpath.sv
hdl/gf2m_multiply_power_inverse_unit.sv
tb/testbench.sv
